>>> rtl/bba_pkg.sv
package bba_pkg;

    // default sizes of the layout
    localparam int NUM_BLOCKS_DEF       = 1024;
    localparam int INODE_COUNT_DEF      = 128;
    localparam int BOOT_BYTES_DEF       = 1024;
    localparam int SUPERBLOCK_BYTES_DEF = 1024;

    // field widths
    localparam int ACTION_W      = 2;
    localparam int ADDR_W        = 32;
    localparam int STATUS_W      = 3;
    localparam int FREE_BLOCKS_W = 11;
    localparam int FREE_INODES_W = 8;
    localparam int FS_W          = 32;
    localparam int BS_W          = 17;
    localparam int INODE_LIST_W  = 24;
    localparam int ROOT_DIR_W    = 24;

    // data area base never exceeds 2^26 over the parameter ranges
    localparam int BASE_W = 27;

    // busy map row organisation
    localparam int ROW_W = 32;
    localparam int BIT_W = 5;

    // register port
    localparam int CFG_AW  = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_FS_BYTES         = 2'd0;
    localparam logic [1:0] REG_BLOCK_BYTES      = 2'd1;
    localparam logic [1:0] REG_INODE_LIST_BYTES = 2'd2;
    localparam logic [1:0] REG_ROOT_DIR_BYTES   = 2'd3;

    localparam logic [FS_W-1:0]         FS_BYTES_RST         = 32'd2097152;
    localparam logic [BS_W-1:0]         BLOCK_BYTES_RST      = 17'd1024;
    localparam logic [INODE_LIST_W-1:0] INODE_LIST_BYTES_RST = 24'd0;
    localparam logic [ROOT_DIR_W-1:0]   ROOT_DIR_BYTES_RST   = 24'd0;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_FIND    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLAIM   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_INODE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_BUSY = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PAST_END = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd6;

    typedef struct packed {
        logic [FS_W-1:0]         fs_bytes;
        logic [BS_W-1:0]         block_bytes;
        logic [INODE_LIST_W-1:0] inode_list_bytes;
        logic [ROOT_DIR_W-1:0]   root_dir_bytes;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic                take;
        logic                pre;
        logic                div_step;
        logic                rd_idx;
        logic                upd;
        logic                srch;
        logic                enc;
        logic                mul;
        logic                fin;
        logic                post;
        logic                found;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                first;
        logic                blk_zero;
        logic                ino_zero;
        logic                outside;
        logic                div_last;
        logic                bit_busy;
        logic                row_free;
        logic                past_end;
        logic                out_free;
    } sts_t;

endpackage

>>> rtl/bba_req_if.sv
interface bba_req_if import bba_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   block_address;
    logic                first_of_inode;

    modport source (output valid, action, block_address, first_of_inode, input ready);
    modport sink (input valid, action, block_address, first_of_inode, output ready);

endinterface

>>> rtl/bba_rsp_if.sv
interface bba_rsp_if import bba_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [ADDR_W-1:0]        found_address;
    logic [STATUS_W-1:0]      status;
    logic [FREE_BLOCKS_W-1:0] free_blocks;
    logic [FREE_INODES_W-1:0] free_inodes;

    modport source (output valid, found_address, status, free_blocks, free_inodes, input ready);
    modport sink (input valid, found_address, status, free_blocks, free_inodes, output ready);

endinterface

>>> rtl/bba_ctrl.sv
module bba_ctrl import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [ACTION_W-1:0] req_action,
    output logic                req_ready,
    input  sts_t                sts,
    output cmd_t                cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRE   = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_RDIDX = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_SRCH  = 4'd5;
    localparam logic [3:0] S_ENC   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_FCHK  = 4'd9;
    localparam logic [3:0] S_POST  = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic                fnd_reg, fnd_next;

    // sequencing of one transaction
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        fnd_next   = fnd_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take = 1'b1;
                    st_next  = ST_OK;
                    fnd_next = 1'b0;
                    state_next = (req_action == ACT_FIND) ? S_SRCH : S_PRE;
                end
            end
            // checks ahead of the index division
            S_PRE:
            begin
                case (sts.action)
                    ACT_CLAIM:
                    begin
                        if (sts.first && sts.ino_zero)
                        begin
                            st_next    = ST_NO_INODE;
                            state_next = S_POST;
                        end
                        else if (sts.blk_zero)
                        begin
                            st_next    = ST_NO_BLOCK;
                            state_next = S_POST;
                        end
                        else if (sts.outside)
                        begin
                            st_next    = ST_OUTSIDE;
                            state_next = S_POST;
                        end
                        else
                        begin
                            cmd.pre    = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (sts.outside)
                        begin
                            st_next    = ST_OUTSIDE;
                            state_next = S_POST;
                        end
                        else
                        begin
                            cmd.pre    = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_POST;
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_RDIDX;
                end
            end
            S_RDIDX:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_UPD;
            end
            // busy check and map write
            S_UPD:
            begin
                state_next = S_POST;
                if (sts.action == ACT_CLAIM)
                begin
                    if (sts.bit_busy)
                    begin
                        st_next = ST_BUSY;
                    end
                    else
                    begin
                        cmd.upd = 1'b1;
                    end
                end
                else
                begin
                    if (!sts.bit_busy)
                    begin
                        st_next = ST_NOT_BUSY;
                    end
                    else
                    begin
                        cmd.upd = 1'b1;
                    end
                end
            end
            // find path
            S_SRCH:
            begin
                if (sts.blk_zero || !sts.row_free)
                begin
                    st_next    = ST_NO_BLOCK;
                    state_next = S_POST;
                end
                else
                begin
                    cmd.srch   = 1'b1;
                    state_next = S_ENC;
                end
            end
            S_ENC:
            begin
                cmd.enc    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (sts.past_end)
                begin
                    st_next = ST_PAST_END;
                end
                else
                begin
                    fnd_next = 1'b1;
                end
                state_next = S_POST;
            end
            // hand over to the output register
            S_POST:
            begin
                if (sts.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.status = st_reg;
        cmd.found  = fnd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            fnd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            fnd_reg   <= fnd_next;
        end
    end

endmodule

>>> rtl/bba_dpath.sv
module bba_dpath import bba_pkg::*;
#(
    parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
    parameter int INODE_COUNT      = INODE_COUNT_DEF,
    parameter int BOOT_BYTES       = BOOT_BYTES_DEF,
    parameter int SUPERBLOCK_BYTES = SUPERBLOCK_BYTES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic [ACTION_W-1:0]       req_action,
    input  logic [ADDR_W-1:0]         req_block_address,
    input  logic                      req_first_of_inode,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [ADDR_W-1:0]         out_found_address,
    output logic [STATUS_W-1:0]       out_status,
    output logic [FREE_BLOCKS_W-1:0]  out_free_blocks,
    output logic [FREE_INODES_W-1:0]  out_free_inodes
);

    localparam int ROWS       = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IW         = ROW_AW + BIT_W;
    localparam int DVW        = IW + BS_W;
    localparam int LIM_W      = BS_W + $clog2(NUM_BLOCKS + 1);
    localparam int CW         = (LIM_W > ADDR_W) ? LIM_W : ADDR_W;
    localparam int RW         = (DVW > ADDR_W) ? DVW : ADDR_W;
    localparam int AW         = ((DVW > BASE_W) ? DVW : BASE_W) + 1;
    localparam int FW         = ((AW > FS_W) ? AW : FS_W) + 1;
    localparam int BLK_CW     = $clog2(NUM_BLOCKS + 1);
    localparam int INO_CW     = $clog2(INODE_COUNT + 1);
    localparam int DCNT_W     = $clog2(IW);
    localparam int CONST_BASE = BOOT_BYTES + SUPERBLOCK_BYTES + NUM_BLOCKS;

    // request and derived layout
    logic [ACTION_W-1:0] act_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                first_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [BS_W-1:0]     bs_reg;
    logic [LIM_W-1:0]    lim_reg;
    logic [BS_W-1:0]     bs_eff;

    // index divider
    logic [ADDR_W-1:0]   rem_reg;
    logic [DVW-1:0]      dvs_reg;
    logic [IW-1:0]       q_reg;
    logic [DCNT_W-1:0]   dcnt_reg;

    // busy map
    logic [ROW_W-1:0]    map_mem [ROWS];
    logic [ROW_W-1:0]    rd_data_reg;
    logic                rd_vld_reg;
    logic [ROW_AW-1:0]   row_reg;
    logic [ROWS-1:0]     row_vld_reg;
    logic [ROWS-1:0]     full_reg;

    // address path of a find
    logic [IW-1:0]       idx_reg;
    logic [DVW-1:0]      prod_reg;
    logic [AW-1:0]       a_reg;

    logic [BLK_CW-1:0]   blk_cnt_reg;
    logic [INO_CW-1:0]   ino_cnt_reg;

    logic [ADDR_W-1:0]   diff;
    logic                below;
    logic                div_ge;
    logic [RW-1:0]       rem_sub;
    logic [ROW_W-1:0]    pad;
    logic [ROW_W-1:0]    word_eff;
    logic [ROW_W-1:0]    word_pad;
    logic [ROW_W-1:0]    new_word;
    logic [BIT_W-1:0]    bit_sel;
    logic [BIT_W-1:0]    free_bit;
    logic [ROW_AW-1:0]   srch_row;
    logic [ROW_AW-1:0]   rd_addr;
    logic                is_claim;

    assign bs_eff   = (cfg.block_bytes == '0) ? BS_W'(1) : cfg.block_bytes;
    assign is_claim = (act_reg == ACT_CLAIM);

    // address range check against the data area
    assign below   = addr_reg < ADDR_W'(base_reg);
    assign diff    = addr_reg - ADDR_W'(base_reg);
    assign div_ge  = RW'(rem_reg) >= RW'(dvs_reg);
    assign rem_sub = RW'(rem_reg) - RW'(dvs_reg);

    // padding bits past the last block read as busy
    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            pad[j] = (int'(row_reg) * ROW_W + j) >= NUM_BLOCKS;
        end
    end

    assign word_eff = rd_vld_reg ? rd_data_reg : '0;
    assign word_pad = word_eff | pad;
    assign bit_sel  = q_reg[BIT_W-1:0];

    always_comb
    begin
        new_word          = word_eff;
        new_word[bit_sel] = is_claim;
    end

    // lowest clear bit of the row read
    always_comb
    begin
        free_bit = '0;
        for (int j = ROW_W - 1; j >= 0; j--)
        begin
            if (!word_pad[j])
            begin
                free_bit = BIT_W'(j);
            end
        end
    end

    // lowest row that still has a free block
    always_comb
    begin
        srch_row = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (!full_reg[r])
            begin
                srch_row = ROW_AW'(r);
            end
        end
    end

    assign rd_addr = cmd.srch ? srch_row : q_reg[IW-1:BIT_W];

    // status back to the controller
    always_comb
    begin
        sts.action   = act_reg;
        sts.first    = first_reg;
        sts.blk_zero = (blk_cnt_reg == '0);
        sts.ino_zero = (ino_cnt_reg == '0);
        sts.outside  = below || (CW'(diff) >= CW'(lim_reg));
        sts.div_last = (dcnt_reg == '0);
        sts.bit_busy = word_eff[bit_sel];
        sts.row_free = !(&full_reg);
        sts.past_end = (FW'(a_reg) + FW'(bs_reg)) >= FW'(cfg.fs_bytes);
        sts.out_free = !out_valid || out_ready;
    end

    // request, layout and arithmetic registers
    always_ff @(posedge clk)
    begin
        base_reg <= BASE_W'(CONST_BASE) + BASE_W'(cfg.inode_list_bytes)
                    + BASE_W'(cfg.root_dir_bytes);
        bs_reg   <= bs_eff;
        lim_reg  <= LIM_W'(bs_eff) * LIM_W'(NUM_BLOCKS);
        if (cmd.take)
        begin
            act_reg   <= req_action;
            addr_reg  <= req_block_address;
            first_reg <= req_first_of_inode;
        end
        if (cmd.pre)
        begin
            rem_reg <= diff;
            dvs_reg <= DVW'(bs_reg) << (IW - 1);
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= ADDR_W'(rem_sub);
            end
            q_reg   <= {q_reg[IW-2:0], div_ge};
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.enc)
        begin
            idx_reg <= {row_reg, free_bit};
        end
        if (cmd.mul)
        begin
            prod_reg <= DVW'(idx_reg) * DVW'(bs_reg);
        end
        if (cmd.fin)
        begin
            a_reg <= AW'(base_reg) + AW'(prod_reg);
        end
        if (cmd.post)
        begin
            out_found_address <= cmd.found ? a_reg[ADDR_W-1:0] : '0;
            out_status        <= cmd.status;
            out_free_blocks   <= FREE_BLOCKS_W'(blk_cnt_reg);
            out_free_inodes   <= FREE_INODES_W'(ino_cnt_reg);
        end
    end

    // busy map storage, one row port
    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            map_mem[row_reg] <= new_word;
        end
        if (cmd.srch || cmd.rd_idx)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // control state, counters and row flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            row_reg     <= '0;
            row_vld_reg <= '0;
            full_reg    <= '0;
            blk_cnt_reg <= BLK_CW'(NUM_BLOCKS);
            ino_cnt_reg <= INO_CW'(INODE_COUNT);
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cmd.pre)
            begin
                dcnt_reg <= DCNT_W'(IW - 1);
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.srch || cmd.rd_idx)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
                row_reg    <= rd_addr;
            end
            if (cmd.upd)
            begin
                row_vld_reg[row_reg] <= 1'b1;
                full_reg[row_reg]    <= &(new_word | pad);
                if (is_claim)
                begin
                    blk_cnt_reg <= blk_cnt_reg - 1'b1;
                    if (first_reg)
                    begin
                        ino_cnt_reg <= ino_cnt_reg - 1'b1;
                    end
                end
                else
                begin
                    if (blk_cnt_reg < BLK_CW'(NUM_BLOCKS))
                    begin
                        blk_cnt_reg <= blk_cnt_reg + 1'b1;
                    end
                    if (first_reg && (ino_cnt_reg < INO_CW'(INODE_COUNT)))
                    begin
                        ino_cnt_reg <= ino_cnt_reg + 1'b1;
                    end
                end
            end
            if (cmd.post)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/bitmap_block_allocator.sv
// sequencing: find runs from acceptance to result through row search, row read, bit encode,
//   index times block size, base add and end check; claim and release run the range
//   checks, the one-bit-a-cycle index divider, the index row read and the map update
// throughput: one transaction at a time, the next accepted the cycle after the result
//   is handed to the output register, which holds it while the next one runs
// reset: counters to full, every map row marked unwritten so it reads free; no clearing pass
module bitmap_block_allocator import bba_pkg::*;
#(
    parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
    parameter int INODE_COUNT      = INODE_COUNT_DEF,
    parameter int BOOT_BYTES       = BOOT_BYTES_DEF,
    parameter int SUPERBLOCK_BYTES = SUPERBLOCK_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    bba_req_if.sink            req,
    bba_rsp_if.source          rsp
);

    cfg_t       cfg_reg;
    cmd_t       cmd;
    sts_t       sts;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_AW-1:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fs_bytes         <= FS_BYTES_RST;
            cfg_reg.block_bytes      <= BLOCK_BYTES_RST;
            cfg_reg.inode_list_bytes <= INODE_LIST_BYTES_RST;
            cfg_reg.root_dir_bytes   <= ROOT_DIR_BYTES_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_FS_BYTES:         cfg_reg.fs_bytes         <= pwdata;
                REG_BLOCK_BYTES:      cfg_reg.block_bytes      <= pwdata[BS_W-1:0];
                REG_INODE_LIST_BYTES: cfg_reg.inode_list_bytes <= pwdata[INODE_LIST_W-1:0];
                REG_ROOT_DIR_BYTES:   cfg_reg.root_dir_bytes   <= pwdata[ROOT_DIR_W-1:0];
                default:              ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            REG_FS_BYTES:         prdata = cfg_reg.fs_bytes;
            REG_BLOCK_BYTES:      prdata = PDATA_W'(cfg_reg.block_bytes);
            REG_INODE_LIST_BYTES: prdata = PDATA_W'(cfg_reg.inode_list_bytes);
            REG_ROOT_DIR_BYTES:   prdata = PDATA_W'(cfg_reg.root_dir_bytes);
            default:              prdata = '0;
        endcase
    end

    bba_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    bba_dpath
    #(
        .NUM_BLOCKS       (NUM_BLOCKS),
        .INODE_COUNT      (INODE_COUNT),
        .BOOT_BYTES       (BOOT_BYTES),
        .SUPERBLOCK_BYTES (SUPERBLOCK_BYTES)
    )
    u_dpath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .req_action         (req.action),
        .req_block_address  (req.block_address),
        .req_first_of_inode (req.first_of_inode),
        .cmd                (cmd),
        .sts                (sts),
        .out_ready          (rsp.ready),
        .out_valid          (rsp.valid),
        .out_found_address  (rsp.found_address),
        .out_status         (rsp.status),
        .out_free_blocks    (rsp.free_blocks),
        .out_free_inodes    (rsp.free_inodes)
    );

`ifndef NO_ASSERTIONS
    // one transaction in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another transaction is in flight");

    // a new result never overwrites one still waiting
    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> sts.out_free)
        else $error("result posted over a pending result");

    // map writes only flip a bit to its opposite state
    a_upd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> ((sts.action == ACT_CLAIM) != sts.bit_busy))
        else $error("map update on a block in the wrong busy state");

    // a claim never takes the block count below zero
    a_claim_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd && (sts.action == ACT_CLAIM)) |-> !sts.blk_zero)
        else $error("claim with no free block left");
`endif

endmodule
